/* sv/fcpwm_pkg.sv */
package fcpwm_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned CHANNELS_MAX = 4;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned PROD_W  = CNT_W + DUTY_W;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  // floor(p / 100) == (p * DIV_MUL) >> DIV_SHIFT for every p below 2**PROD_W
  localparam int unsigned     DIV_SHIFT = 30;
  localparam int unsigned     DIV_MUL_W = 24;
  localparam logic [23:0]     DIV_MUL   = 24'd10737419;

  localparam logic [CNT_W-1:0] RELOAD_RST = 16'hFFFF;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_PRESCALE = 2'd0,
    REG_RELOAD   = 2'd1,
    REG_CH_EN    = 2'd2,
    REG_CTRL     = 2'd3
  } reg_idx_e;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_DUTY = 1'b1
  } req_e;

  typedef struct packed {
    logic [0:0]        req_type;
    logic [CH_W-1:0]   channel;
    logic [DUTY_W-1:0] duty_percent;
  } in_item_t;

  typedef struct packed {
    logic [CHANNELS_MAX-1:0] pwm_out;
    logic [0:0]              update_event;
    logic [CNT_W-1:0]        count_value;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]        prescale_div;
    logic [CNT_W-1:0]        auto_reload;
    logic [CHANNELS_MAX-1:0] channel_enable;
    logic                    counter_on;
  } cfg_t;

endpackage

/* sv/fcpwm_regs.sv */
module fcpwm_regs
  import fcpwm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale_div   <= '0;
      cfg_q.auto_reload    <= RELOAD_RST;
      cfg_q.channel_enable <= '0;
      cfg_q.counter_on     <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRESCALE: cfg_q.prescale_div   <= pwdata[CNT_W-1:0];
        REG_RELOAD:   cfg_q.auto_reload    <= pwdata[CNT_W-1:0];
        REG_CH_EN:    cfg_q.channel_enable <= pwdata[CHANNELS_MAX-1:0];
        REG_CTRL:     cfg_q.counter_on     <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRESCALE: prdata = APB_DW'(cfg_q.prescale_div);
      REG_RELOAD:   prdata = APB_DW'(cfg_q.auto_reload);
      REG_CH_EN:    prdata = APB_DW'(cfg_q.channel_enable);
      REG_CTRL:     prdata = APB_DW'(cfg_q.counter_on);
    endcase
  end

endmodule

/* sv/fcpwm_duty.sv */
module fcpwm_duty
  import fcpwm_pkg::*;
(
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [DUTY_W-1:0] duty_i,
  input  logic [CNT_W-1:0]  reload_i,
  output logic [CNT_W-1:0]  compare_o
);

  logic [DUTY_W-1:0]           duty_c;
  logic [PROD_W-1:0]           prod_d;
  logic [PROD_W-1:0]           prod_q;
  logic [PROD_W+DIV_MUL_W-1:0] recip;

  // clamp to full scale, then duty * reload into the input stage
  assign duty_c = (duty_i > DUTY_FULL) ? DUTY_FULL : duty_i;
  assign prod_d = PROD_W'(duty_c) * PROD_W'(reload_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // divide by 100 through the reciprocal
  assign recip     = (PROD_W+DIV_MUL_W)'(prod_q) * (PROD_W+DIV_MUL_W)'(DIV_MUL);
  assign compare_o = CNT_W'(recip >> DIV_SHIFT);

endmodule

/* sv/fcpwm_core.sv */
module fcpwm_core
  import fcpwm_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  in_item_t         item_i,
  input  logic [CNT_W-1:0] compare_i,
  input  cfg_t             cfg_i,
  output out_item_t        res_o
);

  logic [CNT_W-1:0] pre_q, pre_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] preload_q [CHANNELS];
  logic [CNT_W-1:0] active_q  [CHANNELS];
  logic [CNT_W-1:0] active_d  [CHANNELS];
  logic             run, step, wrap, duty_we;

  assign run     = (req_e'(item_i.req_type) == REQ_TICK) && cfg_i.counter_on;
  assign step    = run && (pre_q >= cfg_i.prescale_div);
  assign wrap    = step && (cnt_q >= cfg_i.auto_reload);
  assign duty_we = (req_e'(item_i.req_type) == REQ_DUTY);

  always_comb begin
    pre_d = pre_q;
    if (run) begin
      pre_d = step ? '0 : CNT_W'(pre_q + 1'b1);
    end
    cnt_d = cnt_q;
    if (step) begin
      cnt_d = wrap ? '0 : CNT_W'(cnt_q + 1'b1);
    end
    for (int c = 0; c < CHANNELS; c++) begin
      active_d[c] = wrap ? preload_q[c] : active_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
      cnt_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        preload_q[c] <= '0;
        active_q[c]  <= '0;
      end
    end else if (fire_i) begin
      pre_q <= pre_d;
      cnt_q <= cnt_d;
      for (int c = 0; c < CHANNELS; c++) begin
        active_q[c] <= active_d[c];
        // channels beyond the instance never match, so such items drop
        if (duty_we && (item_i.channel == CH_W'(c))) begin
          preload_q[c] <= compare_i;
        end
      end
    end
  end

  always_comb begin
    res_o.pwm_out = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      res_o.pwm_out[c] = cfg_i.channel_enable[c] && (cnt_d < active_d[c]);
    end
    res_o.update_event = wrap;
    res_o.count_value  = cnt_d;
  end

endmodule

/* sv/four_channel_pwm_timer.sv */
// Edge-aligned PWM timer with up to four channels. Each item is a timer tick or a duty
// update for one channel; every item returns one result carrying the channel outputs,
// the update flag and the counter value after the item. The block takes one item per
// clock while the result side does not stall; each item passes an input stage that
// also forms duty * reload, then the execute step (prescaler, counter, compare update and
// the divide by 100) into the result register. Registers sit on the APB port at byte
// addresses 0x0 prescaler, 0x4 reload, 0x8 channel enable, 0xC counter on; write them only
// while no item is in flight.
module four_channel_pwm_timer
  import fcpwm_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg;
  logic             s1_valid_q;
  in_item_t         s1_item_q;
  logic             out_valid_q;
  out_item_t        out_item_q;
  out_item_t        res;
  logic [CNT_W-1:0] compare;
  logic             res_free, s1_adv, accept;

  assign res_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && res_free;
  assign in_ready_o = !s1_valid_q || res_free;
  assign accept     = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  fcpwm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fcpwm_duty u_duty (
    .clk_i     (clk_i),
    .load_i    (accept),
    .duty_i    (in_item_i.duty_percent),
    .reload_i  (cfg.auto_reload),
    .compare_o (compare)
  );

  fcpwm_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_adv),
    .item_i    (s1_item_q),
    .compare_i (compare),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
    if (s1_adv) begin
      out_item_q <= res;
    end
  end

endmodule

/* tb/pwm_timer_checker.sv */
module pwm_timer_checker
  import fcpwm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_item_t   in_item_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_item_t  out_item_i,
  input  logic       psel_i,
  input  logic       penable_i,
  input  logic       pwrite_i,
  input  logic       pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirrored register file
  logic [CNT_W-1:0]        div_q;
  logic [CNT_W-1:0]        reload_q;
  logic [CHANNELS_MAX-1:0] enable_q;
  logic                    running_q;

  // timer state as the block should hold it
  logic [CNT_W-1:0] presc_cnt;
  logic [CNT_W-1:0] main_cnt;
  logic [CNT_W-1:0] cmp_preload [CHANNELS_MAX];
  logic [CNT_W-1:0] cmp_active  [CHANNELS_MAX];

  out_item_t expected_results[$];
  out_item_t want;
  int        fails;

  function automatic out_item_t timer_step(in_item_t it);
    out_item_t   r;
    logic        wrapped;
    int unsigned duty;
    wrapped = 1'b0;
    if (req_e'(it.req_type) == REQ_TICK) begin
      if (running_q) begin
        if (presc_cnt >= div_q) begin
          presc_cnt = '0;
          // wrap also when the reload was lowered below the count
          if (main_cnt >= reload_q) begin
            main_cnt   = '0;
            cmp_active = cmp_preload;
            wrapped    = 1'b1;
          end else begin
            main_cnt = main_cnt + 1'b1;
          end
        end else begin
          presc_cnt = presc_cnt + 1'b1;
        end
      end
    end else if (it.channel < CHANNELS_DEF) begin
      duty = 32'((it.duty_percent > DUTY_FULL) ? DUTY_FULL : it.duty_percent);
      cmp_preload[it.channel] = CNT_W'((duty * reload_q) / DUTY_FULL);
    end
    for (int c = 0; c < CHANNELS_MAX; c++) begin
      r.pwm_out[c] = (c < CHANNELS_DEF) && enable_q[c] && (main_cnt < cmp_active[c]);
    end
    r.update_event = wrapped;
    r.count_value  = main_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q     = '0;
      reload_q  = RELOAD_RST;
      enable_q  = '0;
      running_q = 1'b0;
      presc_cnt = '0;
      main_cnt  = '0;
      for (int c = 0; c < CHANNELS_MAX; c++) begin
        cmp_preload[c] = '0;
        cmp_active[c]  = '0;
      end
      expected_results.delete();
      fails = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_PRESCALE: div_q     = pwdata_i[CNT_W-1:0];
          REG_RELOAD:   reload_q  = pwdata_i[CNT_W-1:0];
          REG_CH_EN:    enable_q  = pwdata_i[CHANNELS_MAX-1:0];
          REG_CTRL:     running_q = pwdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(timer_step(in_item_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: %p", out_item_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.pwm_out !== want.pwm_out) begin
            $error("pwm_out: expected %h, got %h", want.pwm_out, out_item_i.pwm_out);
            fails++;
          end
          if (out_item_i.update_event !== want.update_event) begin
            $error("update_event: expected %b, got %b",
                   want.update_event, out_item_i.update_event);
            fails++;
          end
          if (out_item_i.count_value !== want.count_value) begin
            $error("count_value: expected %0d, got %0d",
                   want.count_value, out_item_i.count_value);
            fails++;
          end
        end
      end
    end
    fail_count_o = fails;
    pending_o    = expected_results.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fcpwm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_item_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int          fail_count;
  int          pending;
  logic        steady = 1'b0;
  int unsigned quiet  = 0;

  four_channel_pwm_timer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  pwm_timer_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      out_ready_i <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_item(req_e req, logic [CH_W-1:0] ch, logic [DUTY_W-1:0] duty);
    in_item_t it;
    it.req_type     = req;
    it.channel      = ch;
    it.duty_percent = duty;
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and hold until every result is back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_timer(logic [CNT_W-1:0] div, logic [CNT_W-1:0] reload,
                           logic [CHANNELS_MAX-1:0] en, logic on);
    wait_idle();
    write_reg(REG_PRESCALE, APB_DW'(div));
    write_reg(REG_RELOAD, APB_DW'(reload));
    write_reg(REG_CH_EN, APB_DW'(en));
    write_reg(REG_CTRL, APB_DW'(on));
  endtask

  initial begin
    logic [CNT_W-1:0]        div;
    logic [CNT_W-1:0]        reload;
    logic [CHANNELS_MAX-1:0] en;
    logic                    on;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // counter stopped after reset; duty clamp against full reload
    push_item(REQ_TICK, 2'd0, 7'd0);
    push_item(REQ_DUTY, 2'd3, 7'd127);
    push_item(REQ_DUTY, 2'd0, 7'd0);

    set_timer(16'd0, 16'd4, 4'hF, 1'b1);
    push_item(REQ_DUTY, 2'd0, 7'd50);
    push_item(REQ_DUTY, 2'd1, 7'd100);
    push_item(REQ_DUTY, 2'd2, 7'd101);
    push_item(REQ_DUTY, 2'd1, 7'd25);
    repeat (6) push_item(REQ_TICK, 2'd3, 7'd127);

    // leave the count at three with the prescaler part way
    set_timer(16'd1, 16'd3, 4'b0101, 1'b1);
    repeat (5) push_item(REQ_TICK, 2'd0, 7'd0);

    // reload and divider now below the running values
    set_timer(16'd0, 16'd0, 4'b1010, 1'b1);
    repeat (2) push_item(REQ_TICK, 2'd0, 7'd0);

    set_timer(16'hFFFF, 16'hFFFF, 4'h0, 1'b1);
    repeat (2) push_item(REQ_TICK, 2'd0, 7'd0);
    push_item(REQ_DUTY, 2'd2, 7'd99);

    for (int phase = 0; phase < 10; phase++) begin
      steady = (phase == 4);
      case ($urandom_range(0, 9))
        0:       div = 16'hFFFF;
        1, 2, 3: div = CNT_W'($urandom_range(1, 3));
        default: div = '0;
      endcase
      case ($urandom_range(0, 9))
        0:       reload = '0;
        1:       reload = 16'hFFFF;
        2:       reload = CNT_W'($urandom_range(0, 65535));
        default: reload = CNT_W'($urandom_range(1, 12));
      endcase
      en = (phase == 0) ? 4'hF : CHANNELS_MAX'($urandom_range(0, 15));
      on = (phase == 0) || ($urandom_range(0, 7) != 0);
      set_timer(div, reload, en, on);
      for (int k = 0; k < 130; k++) begin
        if (phase == 6 && k == 65) begin
          wait_idle();
        end
        if ($urandom_range(0, 4) != 0) begin
          push_item(REQ_TICK, CH_W'($urandom_range(0, 3)), DUTY_W'($urandom_range(0, 127)));
        end else if ($urandom_range(0, 9) < 7) begin
          push_item(REQ_DUTY, CH_W'($urandom_range(0, 3)), DUTY_W'($urandom_range(0, 100)));
        end else begin
          push_item(REQ_DUTY, CH_W'($urandom_range(0, 3)), DUTY_W'($urandom_range(0, 127)));
        end
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
